>>> rtl/lfsc_pkg.sv
package lfsc_pkg;

	localparam int NUM_SENSORS = 8;
	localparam int SENSE_USED = (NUM_SENSORS < 8) ? NUM_SENSORS : 8;

	// Widths of the shared restoring divider.
	localparam int DIV_W = 20;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int ERR_MAG_W = 7;

	localparam logic [11:0] BASE_DUTY_RST = 12'd680;
	localparam logic [8:0] STEER_GAIN_RST = 9'd55;
	localparam logic [7:0] LSCALE_NUM_RST = 8'd81;
	localparam logic [7:0] LSCALE_DEN_RST = 8'd100;
	localparam logic [11:0] DUTY_LIMIT_RST = 12'd3599;
	localparam logic [15:0] BEEP_ON_RST = 16'd150;
	localparam logic [15:0] BEEP_OFF_RST = 16'd350;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		REG_BASE_DUTY = 3'd0,
		REG_STEER_GAIN = 3'd1,
		REG_LSCALE_NUM = 3'd2,
		REG_LSCALE_DEN = 3'd3,
		REG_DUTY_LIMIT = 3'd4,
		REG_BEEP_ON = 3'd5,
		REG_BEEP_OFF = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic command;
		logic [7:0] sensor_mask;
		logic load_present;
	} in_item_t;

	typedef struct packed {
		logic [11:0] left_duty;
		logic [11:0] right_duty;
		logic signed [3:0] line_error;
		logic beeper_on;
	} out_item_t;

	typedef struct packed {
		logic [11:0] base_duty;
		logic [8:0] steer_gain;
		logic [7:0] left_scale_num;
		logic [7:0] left_scale_den;
		logic [11:0] duty_limit;
		logic [15:0] beep_on_time;
		logic [15:0] beep_off_time;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic err_div_start;
		logic err_latch;
		logic turn;
		logic clamp;
		logic scale_mul;
		logic scale_div_start;
		logic div_step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic tick;
		logic load;
		logic cnt_zero;
		logic div_done;
	} dp_status_t;

endpackage

>>> rtl/line_follow_steering_controller.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data  (command, sensor_mask, load_present)
// out       output     out_valid / out_stall  out_data (left_duty, right_duty, line_error,
//                                                       beeper_on)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A tick, or a control step without a load, passes the decide state and
// goes to the finish state; a loaded step also runs the shared restoring divider: 7 steps for
// the line error (skipped with no sensor on the line) and 20 for the left scaling.
// Reset clears all steering and beeper state and loads the default register values.
// A new beat is taken the cycle after a result is formed; a finished item waits while a
// stalled result still holds the output register.
module line_follow_steering_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lfsc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lfsc_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import lfsc_pkg::*;

	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_duty <= BASE_DUTY_RST;
			cfg_q.steer_gain <= STEER_GAIN_RST;
			cfg_q.left_scale_num <= LSCALE_NUM_RST;
			cfg_q.left_scale_den <= LSCALE_DEN_RST;
			cfg_q.duty_limit <= DUTY_LIMIT_RST;
			cfg_q.beep_on_time <= BEEP_ON_RST;
			cfg_q.beep_off_time <= BEEP_OFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BASE_DUTY: cfg_q.base_duty <= cfg_data[11:0];
				REG_STEER_GAIN: cfg_q.steer_gain <= cfg_data[8:0];
				REG_LSCALE_NUM: cfg_q.left_scale_num <= cfg_data[7:0];
				REG_LSCALE_DEN: cfg_q.left_scale_den <= cfg_data[7:0];
				REG_DUTY_LIMIT: cfg_q.duty_limit <= cfg_data[11:0];
				REG_BEEP_ON: cfg_q.beep_on_time <= cfg_data;
				REG_BEEP_OFF: cfg_q.beep_off_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lfsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd(cmd),
		.in_stall(in_stall),
		.out_valid(out_valid)
	);

	lfsc_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_data(in_data),
		.cmd(cmd),
		.status(status),
		.out_data(out_data)
	);

`ifndef SYNTH
	// The beeper only sounds while both wheels are stopped.
	a_beep_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.beeper_on) |-> (out_data.left_duty == 12'd0 &&
			out_data.right_duty == 12'd0))
		else $error("beeper on with a wheel driven");

	// The held error never leaves -7..7.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.line_error != 4'sb1000))
		else $error("line error out of range");

	// An accepted beat keeps the input side stalled until its result is formed.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !cmd.commit))
		else $error("input accepted while an item is in flight");

	// The result register is never overwritten while a beat waits in it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");
`endif

endmodule

>>> rtl/lfsc_ctrl.sv
module lfsc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_stall,
	input lfsc_pkg::dp_status_t status,
	output lfsc_pkg::dp_cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);
	import lfsc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_ERR_DIV,
		S_ERR,
		S_TURN,
		S_CLAMP,
		S_MUL,
		S_SDIV_START,
		S_SCALE_DIV,
		S_FINISH
	} state_t;

	state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.tick || !status.load) begin
					state_nxt = S_FINISH;
				end else if (status.cnt_zero) begin
					state_nxt = S_ERR;
				end else begin
					cmd.err_div_start = 1'b1;
					state_nxt = S_ERR_DIV;
				end
			end
			S_ERR_DIV: begin
				if (status.div_done) begin
					state_nxt = S_ERR;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_ERR: begin
				cmd.err_latch = 1'b1;
				state_nxt = S_TURN;
			end
			S_TURN: begin
				cmd.turn = 1'b1;
				state_nxt = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.scale_mul = 1'b1;
				state_nxt = S_SDIV_START;
			end
			S_SDIV_START: begin
				cmd.scale_div_start = 1'b1;
				state_nxt = S_SCALE_DIV;
			end
			S_SCALE_DIV: begin
				if (status.div_done) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/lfsc_dpath.sv
module lfsc_dpath (
	input logic clk,
	input logic arst_n,
	input lfsc_pkg::cfg_t cfg,
	input lfsc_pkg::in_item_t in_data,
	input lfsc_pkg::dp_cmd_t cmd,
	output lfsc_pkg::dp_status_t status,
	output lfsc_pkg::out_item_t out_data
);
	import lfsc_pkg::*;

	in_item_t item_q;

	// Controller state that persists between items.
	logic signed [3:0] held_q;
	logic [11:0] left_q, right_q;
	logic loadf_q, beep_q;
	logic [15:0] elapsed_q;

	logic signed [3:0] err_q;
	logic signed [13:0] turn_q;
	logic [11:0] lraw_q, rraw_q;
	logic [DIV_W-1:0] prod_q;

	logic [DIV_W-1:0] quo_q;
	logic [7:0] rem_q, div_q;
	logic [DCNT_W-1:0] dcnt_q;

	out_item_t out_q;

	logic signed [7:0] sum;
	logic [3:0] cnt;
	logic sum_neg;
	logic [ERR_MAG_W-1:0] mag;

	logic [8:0] trial;
	logic trial_ge;

	logic [2:0] qclamp;
	logic signed [3:0] err_nxt;
	logic signed [13:0] gain_s, err_s;
	logic signed [14:0] base_s, lsum, rsum;
	logic [11:0] lcomp;

	logic signed [3:0] held_nxt;
	logic [11:0] left_nxt, right_nxt;
	logic loadf_nxt, beep_nxt, alert;
	logic [15:0] elapsed_nxt, elapsed_inc, phase;

	function automatic logic [11:0] clamp_duty(logic signed [14:0] v, logic [11:0] lim);
		logic [11:0] r;
		if (v < 15'sd0) begin
			r = 12'd0;
		end else if (v > $signed({3'b000, lim})) begin
			r = lim;
		end else begin
			r = v[11:0];
		end
		return r;
	endfunction

	// Weighted position sum and count of sensors that see the line.
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < SENSE_USED; i++) begin
			if (item_q.sensor_mask[i]) begin
				sum = sum + 8'(2 * i - (NUM_SENSORS - 1));
				cnt = cnt + 4'd1;
			end
		end
		sum_neg = sum[7];
		mag = ERR_MAG_W'(sum_neg ? -sum : sum);
	end

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign trial_ge = trial >= {1'b0, div_q};

	always_comb begin
		qclamp = (quo_q[ERR_MAG_W-1:0] > ERR_MAG_W'(7)) ? 3'd7 : quo_q[2:0];
		if (status.cnt_zero) begin
			err_nxt = held_q;
		end else if (sum_neg) begin
			err_nxt = 4'(4'd0 - {1'b0, qclamp});
		end else begin
			err_nxt = {1'b0, qclamp};
		end
	end

	assign gain_s = 14'(cfg.steer_gain);
	assign err_s = 14'(err_q);
	assign base_s = 15'(cfg.base_duty);
	assign lsum = base_s - 15'(turn_q);
	assign rsum = base_s + 15'(turn_q);

	always_comb begin
		if (cfg.left_scale_den == 8'd0) begin
			lcomp = cfg.duty_limit;
		end else if (quo_q > DIV_W'(cfg.duty_limit)) begin
			lcomp = cfg.duty_limit;
		end else begin
			lcomp = quo_q[11:0];
		end
	end

	// Next persistent state at the end of an item.
	always_comb begin
		held_nxt = held_q;
		left_nxt = left_q;
		right_nxt = right_q;
		loadf_nxt = loadf_q;
		beep_nxt = beep_q;
		elapsed_nxt = elapsed_q;
		elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
		phase = beep_q ? cfg.beep_on_time : cfg.beep_off_time;
		alert = 1'b0;
		if (item_q.command == CMD_STEP) begin
			loadf_nxt = item_q.load_present;
			if (item_q.load_present) begin
				held_nxt = err_q;
				left_nxt = lcomp;
				right_nxt = rraw_q;
			end else begin
				left_nxt = 12'd0;
				right_nxt = 12'd0;
			end
			alert = loadf_nxt && (left_nxt == 12'd0) && (right_nxt == 12'd0);
			if (!alert) begin
				beep_nxt = 1'b0;
				elapsed_nxt = 16'd0;
			end
		end else begin
			alert = loadf_q && (left_q == 12'd0) && (right_q == 12'd0);
			if (!alert) begin
				beep_nxt = 1'b0;
				elapsed_nxt = 16'd0;
			end else if (elapsed_inc >= phase) begin
				beep_nxt = !beep_q;
				elapsed_nxt = 16'd0;
			end else begin
				elapsed_nxt = elapsed_inc;
			end
		end
	end

	assign status.tick = (item_q.command == CMD_TICK);
	assign status.load = item_q.load_present;
	assign status.cnt_zero = (cnt == 4'd0);
	assign status.div_done = (dcnt_q == '0);

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			left_q <= '0;
			right_q <= '0;
			loadf_q <= 1'b0;
			beep_q <= 1'b0;
			elapsed_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.commit) begin
				held_q <= held_nxt;
				left_q <= left_nxt;
				right_q <= right_nxt;
				loadf_q <= loadf_nxt;
				beep_q <= beep_nxt;
				elapsed_q <= elapsed_nxt;
			end
			if (cmd.err_div_start) begin
				dcnt_q <= DCNT_W'(ERR_MAG_W);
			end else if (cmd.scale_div_start) begin
				dcnt_q <= DCNT_W'(DIV_W);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_data;
		end
		if (cmd.err_latch) begin
			err_q <= err_nxt;
		end
		if (cmd.turn) begin
			turn_q <= gain_s * err_s;
		end
		if (cmd.clamp) begin
			lraw_q <= clamp_duty(lsum, cfg.duty_limit);
			rraw_q <= clamp_duty(rsum, cfg.duty_limit);
		end
		if (cmd.scale_mul) begin
			prod_q <= DIV_W'(lraw_q) * DIV_W'(cfg.left_scale_num);
		end
		// Restoring division, one quotient bit per step.
		if (cmd.err_div_start) begin
			quo_q <= {mag, {(DIV_W - ERR_MAG_W){1'b0}}};
			rem_q <= '0;
			div_q <= 8'(cnt);
		end else if (cmd.scale_div_start) begin
			quo_q <= prod_q;
			rem_q <= '0;
			div_q <= cfg.left_scale_den;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DIV_W-2:0], trial_ge};
			rem_q <= trial_ge ? 8'(trial - {1'b0, div_q}) : trial[7:0];
		end
		if (cmd.commit) begin
			out_q.left_duty <= left_nxt;
			out_q.right_duty <= right_nxt;
			out_q.line_error <= held_nxt;
			out_q.beeper_on <= beep_nxt;
		end
	end

endmodule
